// ===== hw/rtl/fspm_pkg.sv =====
package fspm_pkg;

    localparam int NUM_SLOTS_DEF = 256;
    localparam int RESET_COUNT   = 200;
    localparam int MIN_COUNT     = 2;
    localparam int CFG_W         = 9;

    typedef enum logic [2:0] {
        OP_NEW     = 3'd0,
        OP_COMMIT  = 3'd1,
        OP_ABORT   = 3'd2,
        OP_GET     = 3'd3,
        OP_RELEASE = 3'd4,
        OP_PUTBACK = 3'd5,
        OP_FLUSH   = 3'd6,
        OP_BAD     = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_ERR   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_READ,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] slot;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slot_out;
        logic        dropped;
        logic [31:0] drop_run;
        logic [31:0] drop_run_max;
        logic [8:0]  queue_count;
        logic [8:0]  free_count;
    } t_result;

    typedef struct packed {
        t_op        op;
        logic [7:0] slot;
    } t_qdata;

endpackage

// ===== hw/rtl/fspm_front.sv =====
module fspm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  fspm_pkg::t_item i_in,
    output logic            o_q_valid,
    output fspm_pkg::t_qdata o_q_data,
    input  logic            i_q_pop
);
    import fspm_pkg::*;

    t_qdata     r_q [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_cnt, n_cnt;
    logic       push;
    t_qdata     cls;

    // classify the raw op code; code seven falls to the misuse class
    always_comb begin
        cls.slot = i_in.slot;
        unique case (i_in.op)
            OP_NEW:     cls.op = OP_NEW;
            OP_COMMIT:  cls.op = OP_COMMIT;
            OP_ABORT:   cls.op = OP_ABORT;
            OP_GET:     cls.op = OP_GET;
            OP_RELEASE: cls.op = OP_RELEASE;
            OP_PUTBACK: cls.op = OP_PUTBACK;
            OP_FLUSH:   cls.op = OP_FLUSH;
            default:    cls.op = OP_BAD;
        endcase
    end

    assign o_in_stall = (r_cnt == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_data   = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_q_pop ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt + {1'b0, push} - {1'b0, i_q_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

endmodule

// ===== hw/rtl/fspm_back.sv =====
module fspm_back #(
    parameter int NUM_SLOTS = fspm_pkg::NUM_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  fspm_pkg::t_qdata  i_q_data,
    output logic              o_q_pop,
    input  logic              i_cfg_valid,
    input  logic [fspm_pkg::CFG_W-1:0] i_cfg_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output fspm_pkg::t_result o_out
);
    import fspm_pkg::*;

    localparam int IW     = $clog2(NUM_SLOTS);
    localparam int CW     = $clog2(NUM_SLOTS + 1);
    localparam int CMPW   = (IW > 8) ? IW : 8;
    localparam int RST_CNT = (RESET_COUNT > NUM_SLOTS) ? NUM_SLOTS : RESET_COUNT;

    logic [IW-1:0] r_link [NUM_SLOTS];
    logic [IW-1:0] r_rd_data;
    logic [IW-1:0] rd_addr;
    logic          we;
    logic [IW-1:0] wa, wd;

    t_state        r_state, n_state;
    logic [IW-1:0] r_sweep_idx, n_sweep_idx;
    t_qdata        r_req, n_req;

    logic [CW-1:0] r_slot_count, n_slot_count;
    logic [IW-1:0] r_free_head, n_free_head, r_free_tail, n_free_tail;
    logic [IW-1:0] r_ready_head, n_ready_head, r_ready_tail, n_ready_tail;
    logic [CW-1:0] r_free_size, n_free_size, r_ready_size, n_ready_size;
    logic          r_prod_valid, n_prod_valid, r_cons_valid, n_cons_valid;
    logic [IW-1:0] r_prod_slot, n_prod_slot, r_cons_slot, n_cons_slot;
    logic [31:0]   r_run, n_run, r_peak, n_peak;
    logic          r_out_valid, n_out_valid;
    t_result       r_out, n_out;

    logic          out_free;
    logic [CW-1:0] cfg_cnt;
    logic [IW-1:0] granted;
    logic [1:0]    status;
    logic          dropped;
    logic          prod_match, cons_match;

    // clamp a written count into 2..NUM_SLOTS
    always_comb begin
        if (i_cfg_data < CFG_W'(MIN_COUNT)) begin
            cfg_cnt = CW'(MIN_COUNT);
        end else if ({5'd0, i_cfg_data} > 14'(NUM_SLOTS)) begin
            cfg_cnt = CW'(NUM_SLOTS);
        end else begin
            cfg_cnt = CW'(i_cfg_data);
        end
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign prod_match = r_prod_valid && (CMPW'(r_prod_slot) == CMPW'(r_req.slot));
    assign cons_match = r_cons_valid && (CMPW'(r_cons_slot) == CMPW'(r_req.slot));

    always_comb begin
        unique case (r_req.op)
            OP_NEW:  rd_addr = (r_free_size != '0) ? r_free_head : r_ready_head;
            OP_GET:  rd_addr = r_ready_head;
            default: rd_addr = r_free_head;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_sweep_idx  = r_sweep_idx;
        n_req        = r_req;
        n_slot_count = r_slot_count;
        n_free_head  = r_free_head;
        n_free_tail  = r_free_tail;
        n_free_size  = r_free_size;
        n_ready_head = r_ready_head;
        n_ready_tail = r_ready_tail;
        n_ready_size = r_ready_size;
        n_prod_valid = r_prod_valid;
        n_prod_slot  = r_prod_slot;
        n_cons_valid = r_cons_valid;
        n_cons_slot  = r_cons_slot;
        n_run        = r_run;
        n_peak       = r_peak;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        o_q_pop      = 1'b0;
        we           = 1'b0;
        wa           = r_sweep_idx;
        wd           = (r_sweep_idx == IW'(NUM_SLOTS - 1)) ? '0 : r_sweep_idx + IW'(1);
        granted      = '0;
        status       = ST_OK;
        dropped      = 1'b0;

        unique case (r_state)
            S_SWEEP: begin
                we = 1'b1;
                n_sweep_idx = r_sweep_idx + IW'(1);
                if (r_sweep_idx == IW'(NUM_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_req   = i_q_data;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    unique case (r_req.op)
                        OP_NEW: begin
                            if (r_prod_valid) begin
                                status = ST_ERR;
                            end else if (r_free_size != '0) begin
                                granted      = r_free_head;
                                n_free_head  = r_rd_data;
                                n_free_size  = r_free_size - CW'(1);
                                n_prod_valid = 1'b1;
                                n_prod_slot  = r_free_head;
                                n_run        = '0;
                            end else if (r_ready_size != '0) begin
                                granted      = r_ready_head;
                                n_ready_head = r_rd_data;
                                n_ready_size = r_ready_size - CW'(1);
                                n_prod_valid = 1'b1;
                                n_prod_slot  = r_ready_head;
                                dropped      = 1'b1;
                                if (r_run != '1) begin
                                    n_run = r_run + 32'd1;
                                end
                                if (n_run > r_peak) begin
                                    n_peak = n_run;
                                end
                            end else begin
                                status = ST_ERR;
                            end
                        end
                        OP_COMMIT: begin
                            if (!prod_match) begin
                                status = ST_ERR;
                            end else begin
                                if (r_ready_size == '0) begin
                                    n_ready_head = r_prod_slot;
                                end else begin
                                    we = 1'b1;
                                    wa = r_ready_tail;
                                    wd = r_prod_slot;
                                end
                                n_ready_tail = r_prod_slot;
                                n_ready_size = r_ready_size + CW'(1);
                                n_prod_valid = 1'b0;
                            end
                        end
                        OP_ABORT, OP_RELEASE: begin
                            if ((r_req.op == OP_ABORT) ? !prod_match : !cons_match) begin
                                status = ST_ERR;
                            end else begin
                                we = 1'b1;
                                wa = (r_req.op == OP_ABORT) ? r_prod_slot : r_cons_slot;
                                wd = r_free_head;
                                if (r_free_size == '0) begin
                                    n_free_tail = wa;
                                end
                                n_free_head = wa;
                                n_free_size = r_free_size + CW'(1);
                                if (r_req.op == OP_ABORT) begin
                                    n_prod_valid = 1'b0;
                                end else begin
                                    n_cons_valid = 1'b0;
                                end
                            end
                        end
                        OP_GET: begin
                            if (r_cons_valid) begin
                                status = ST_ERR;
                            end else if (r_ready_size == '0) begin
                                status = ST_EMPTY;
                            end else begin
                                granted      = r_ready_head;
                                n_ready_head = r_rd_data;
                                n_ready_size = r_ready_size - CW'(1);
                                n_cons_valid = 1'b1;
                                n_cons_slot  = r_ready_head;
                            end
                        end
                        OP_PUTBACK: begin
                            if (!cons_match) begin
                                status = ST_ERR;
                            end else begin
                                we = 1'b1;
                                wa = r_cons_slot;
                                wd = r_ready_head;
                                if (r_ready_size == '0) begin
                                    n_ready_tail = r_cons_slot;
                                end
                                n_ready_head = r_cons_slot;
                                n_ready_size = r_ready_size + CW'(1);
                                n_cons_valid = 1'b0;
                            end
                        end
                        OP_FLUSH: begin
                            if (r_ready_size != '0) begin
                                if (r_free_size == '0) begin
                                    n_free_head = r_ready_head;
                                end else begin
                                    we = 1'b1;
                                    wa = r_free_tail;
                                    wd = r_ready_head;
                                end
                                n_free_tail  = r_ready_tail;
                                n_free_size  = r_free_size + r_ready_size;
                                n_ready_size = '0;
                            end
                        end
                        default: begin
                            status = ST_ERR;
                        end
                    endcase
                    n_out_valid        = 1'b1;
                    n_out.status       = status;
                    n_out.slot_out     = 8'(granted);
                    n_out.dropped      = dropped;
                    n_out.drop_run     = n_run;
                    n_out.drop_run_max = n_peak;
                    n_out.queue_count  = 9'(n_ready_size);
                    n_out.free_count   = 9'(n_free_size);
                    // chain straight into the next read when work is waiting
                    if (i_q_valid) begin
                        o_q_pop = 1'b1;
                        n_req   = i_q_data;
                        n_state = S_READ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        // count write rebuilds the lists and restarts the link sweep
        if (i_cfg_valid) begin
            n_state      = S_SWEEP;
            n_sweep_idx  = '0;
            n_slot_count = cfg_cnt;
            n_free_head  = '0;
            n_free_tail  = IW'(cfg_cnt - CW'(1));
            n_free_size  = cfg_cnt;
            n_ready_head = '0;
            n_ready_tail = '0;
            n_ready_size = '0;
            n_prod_valid = 1'b0;
            n_cons_valid = 1'b0;
            n_prod_slot  = '0;
            n_cons_slot  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_sweep_idx  <= '0;
            r_slot_count <= CW'(RST_CNT);
            r_free_head  <= '0;
            r_free_tail  <= IW'(RST_CNT - 1);
            r_free_size  <= CW'(RST_CNT);
            r_ready_head <= '0;
            r_ready_tail <= '0;
            r_ready_size <= '0;
            r_prod_valid <= 1'b0;
            r_cons_valid <= 1'b0;
            r_prod_slot  <= '0;
            r_cons_slot  <= '0;
            r_run        <= '0;
            r_peak       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep_idx  <= n_sweep_idx;
            r_slot_count <= n_slot_count;
            r_free_head  <= n_free_head;
            r_free_tail  <= n_free_tail;
            r_free_size  <= n_free_size;
            r_ready_head <= n_ready_head;
            r_ready_tail <= n_ready_tail;
            r_ready_size <= n_ready_size;
            r_prod_valid <= n_prod_valid;
            r_cons_valid <= n_cons_valid;
            r_prod_slot  <= n_prod_slot;
            r_cons_slot  <= n_cons_slot;
            r_run        <= n_run;
            r_peak       <= n_peak;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_link[wa] <= wd;
        end
        r_rd_data <= r_link[rd_addr];
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== hw/rtl/frame_slot_pool_manager.sv =====
// channel   direction  handshake            payload
// in        input      i_in_valid/o_in_stall  fspm_pkg::t_item
// out       output     o_out_valid/i_out_stall fspm_pkg::t_result
// cfg       input      i_cfg_valid/o_cfg_ready i_cfg_data (slot_count)
//
// each request does a link memory read, then update and writeback (held while output stalls)
// a two-entry request queue sits between the decode front and the list engine
// after reset and after every slot_count write all NUM_SLOTS link memory entries are swept,
// during which requests queue up but are not executed
// a stalled result holds in the output register while the next request reads memory
module frame_slot_pool_manager #(
    parameter int NUM_SLOTS = fspm_pkg::NUM_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  fspm_pkg::t_item   i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output fspm_pkg::t_result o_out,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [fspm_pkg::CFG_W-1:0] i_cfg_data
);
    import fspm_pkg::*;

    logic   q_valid;
    logic   q_pop;
    t_qdata q_data;

    assign o_cfg_ready = 1'b1;

    fspm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_q_valid  (q_valid),
        .o_q_data   (q_data),
        .i_q_pop    (q_pop)
    );

    fspm_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

// ===== hw/rtl/fspm_checker.sv =====
module fspm_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input fspm_pkg::t_item   i_in,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input fspm_pkg::t_result o_out,
    input logic              i_cfg_valid,
    input logic              o_cfg_ready,
    input logic [fspm_pkg::CFG_W-1:0] i_cfg_data
);
    import fspm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.drop_run_max >= o_out.drop_run)
        else $error("drop run above its maximum");

    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.dropped |-> o_out.status == ST_OK && o_out.drop_run != 32'd0)
        else $error("drop without a counted run");

    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != ST_OK |-> o_out.slot_out == 8'd0 && !o_out.dropped)
        else $error("failed request granted a slot");

endmodule

bind frame_slot_pool_manager fspm_checker u_chk (.*);

// ===== dv/frame_slot_pool_manager_tb.sv =====
`timescale 1ns / 1ps

module frame_slot_pool_manager_tb;
    import fspm_pkg::*;

    localparam int NSLOT = 256;
    localparam int WATCHDOG_LIMIT = 20000;

    // slot-pool predictor and queue of expected results
    class pool_scoreboard;
        logic [7:0]  link_mem [NSLOT];
        logic [7:0]  free_head, free_tail, ready_head, ready_tail;
        logic [8:0]  free_size, ready_size;
        bit          prod_has, cons_has;
        logic [7:0]  prod_slot, cons_slot;
        logic [31:0] run_cnt, run_peak;
        logic [8:0]  pool_size;
        t_result     pending [$];
        int          err_count;

        function void rebuild();
            for (int i = 0; i < NSLOT; i++) link_mem[i] = 8'(i + 1);
            free_head = 0;
            free_tail = 8'(pool_size - 1);
            free_size = pool_size;
            ready_head = 0;
            ready_tail = 0;
            ready_size = 0;
            prod_has = 0;
            cons_has = 0;
            prod_slot = 0;
            cons_slot = 0;
        endfunction

        function void power_up();
            run_cnt = 0;
            run_peak = 0;
            pool_size = RESET_COUNT;
            err_count = 0;
            rebuild();
        endfunction

        function void set_pool(logic [8:0] v);
            pool_size = v < MIN_COUNT ? 9'(MIN_COUNT) : (v > NSLOT ? 9'(NSLOT) : v);
            rebuild();
        endfunction

        function void note_request(t_item it);
            t_result r;
            logic [7:0] s;
            r = '0;
            r.status = ST_OK;
            case (t_op'(it.op))
                OP_NEW: begin
                    if (prod_has) begin
                        r.status = ST_ERR;
                    end else if (free_size > 0) begin
                        s = free_head;
                        free_head = link_mem[s];
                        free_size--;
                        prod_slot = s;
                        prod_has = 1;
                        r.slot_out = s;
                        run_cnt = 0;
                    end else if (ready_size > 0) begin
                        s = ready_head;
                        ready_head = link_mem[s];
                        ready_size--;
                        prod_slot = s;
                        prod_has = 1;
                        r.slot_out = s;
                        r.dropped = 1;
                        if (run_cnt != '1) run_cnt++;
                        if (run_cnt > run_peak) run_peak = run_cnt;
                    end else begin
                        r.status = ST_ERR;
                    end
                end
                OP_COMMIT, OP_ABORT: begin
                    if (!prod_has || prod_slot != it.slot) begin
                        r.status = ST_ERR;
                    end else if (t_op'(it.op) == OP_COMMIT) begin
                        if (ready_size == 0) ready_head = prod_slot;
                        else link_mem[ready_tail] = prod_slot;
                        ready_tail = prod_slot;
                        ready_size++;
                        prod_has = 0;
                    end else begin
                        link_mem[prod_slot] = free_head;
                        if (free_size == 0) free_tail = prod_slot;
                        free_head = prod_slot;
                        free_size++;
                        prod_has = 0;
                    end
                end
                OP_GET: begin
                    if (cons_has) begin
                        r.status = ST_ERR;
                    end else if (ready_size == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        s = ready_head;
                        ready_head = link_mem[s];
                        ready_size--;
                        cons_slot = s;
                        cons_has = 1;
                        r.slot_out = s;
                    end
                end
                OP_RELEASE, OP_PUTBACK: begin
                    if (!cons_has || cons_slot != it.slot) begin
                        r.status = ST_ERR;
                    end else if (t_op'(it.op) == OP_RELEASE) begin
                        link_mem[cons_slot] = free_head;
                        if (free_size == 0) free_tail = cons_slot;
                        free_head = cons_slot;
                        free_size++;
                        cons_has = 0;
                    end else begin
                        link_mem[cons_slot] = ready_head;
                        if (ready_size == 0) ready_tail = cons_slot;
                        ready_head = cons_slot;
                        ready_size++;
                        cons_has = 0;
                    end
                end
                OP_FLUSH: begin
                    if (ready_size > 0) begin
                        if (free_size == 0) free_head = ready_head;
                        else link_mem[free_tail] = ready_head;
                        free_tail = ready_tail;
                        free_size += ready_size;
                        ready_size = 0;
                    end
                end
                default: r.status = ST_ERR;
            endcase
            r.drop_run = run_cnt;
            r.drop_run_max = run_peak;
            r.queue_count = ready_size;
            r.free_count = free_size;
            pending.push_back(r);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
            err_count++;
        endtask

        task check_result(t_result got);
            t_result w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
                return;
            end
            w = pending.pop_front();
            if (got.status !== w.status) report_mismatch("status", got.status, w.status);
            if (got.slot_out !== w.slot_out) report_mismatch("slot_out", got.slot_out, w.slot_out);
            if (got.dropped !== w.dropped) report_mismatch("dropped", got.dropped, w.dropped);
            if (got.drop_run !== w.drop_run) report_mismatch("drop_run", got.drop_run, w.drop_run);
            if (got.drop_run_max !== w.drop_run_max)
                report_mismatch("drop_run_max", got.drop_run_max, w.drop_run_max);
            if (got.queue_count !== w.queue_count)
                report_mismatch("queue_count", got.queue_count, w.queue_count);
            if (got.free_count !== w.free_count)
                report_mismatch("free_count", got.free_count, w.free_count);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_item       i_in;
    logic        o_out_valid;
    logic        i_out_stall;
    t_result     o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [8:0]  i_cfg_data;

    pool_scoreboard sb;
    bit          calm;          // no random idling while set
    bit          hold_off_req;
    int          idle_cycles;

    frame_slot_pool_manager dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // accept-side and result-side monitor, plus idle count for the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_request(i_in);
            if (o_out_valid && !i_out_stall) sb.check_result(o_out);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver stall, with one long hold-off on request
    initial begin
        i_out_stall = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_out_stall <= 1;
                repeat (300) @(negedge i_clk);
                hold_off_req = 0;
                i_out_stall <= 0;
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < 12);
            end
        end
    end

    task automatic send_request(t_op op, logic [7:0] s);
        while (!calm && $urandom_range(99) < 12) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_in.op <= op;
        i_in.slot <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_pool_size(logic [8:0] v);
        drain_results();
        i_cfg_valid <= 1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_pool(v);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    // random request biased toward the held slot so most handshakes succeed
    task automatic random_request();
        int r;
        t_op op;
        logic [7:0] s;
        r = $urandom_range(99);
        if (r < 30) op = OP_NEW;
        else if (r < 45) op = OP_COMMIT;
        else if (r < 52) op = OP_ABORT;
        else if (r < 72) op = OP_GET;
        else if (r < 84) op = OP_RELEASE;
        else if (r < 92) op = OP_PUTBACK;
        else if (r < 97) op = OP_FLUSH;
        else op = OP_BAD;
        if (op == OP_COMMIT || op == OP_ABORT)
            s = ($urandom_range(9) == 0) ? 8'($urandom) : sb.prod_slot;
        else if (op == OP_RELEASE || op == OP_PUTBACK)
            s = ($urandom_range(9) == 0) ? 8'($urandom) : sb.cons_slot;
        else
            s = 8'($urandom);
        send_request(op, s);
    endtask

    initial begin
        logic [8:0] sizes [6];
        sb = new();
        sb.power_up();
        calm = 0;
        hold_off_req = 0;
        idle_cycles = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_in = '0;
        i_cfg_valid = 0;
        i_cfg_data = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: empty get, misuse, fill and drop, flush, bad op, pool size clamping
        send_request(OP_GET, 8'h00);
        send_request(OP_COMMIT, 8'h00);
        send_request(OP_RELEASE, 8'hff);
        send_request(OP_NEW, 8'h00);
        send_request(OP_NEW, 8'h00);
        send_request(OP_COMMIT, 8'h05);
        send_request(OP_COMMIT, 8'h00);
        send_request(OP_FLUSH, 8'h00);
        send_request(OP_FLUSH, 8'h00);
        send_request(OP_BAD, 8'h00);
        write_pool_size(9'd0);
        for (int i = 0; i < 2; i++) begin
            send_request(OP_NEW, 8'h00);
            send_request(OP_COMMIT, sb.prod_slot);
        end
        send_request(OP_NEW, 8'h00);      // drop oldest
        send_request(OP_COMMIT, sb.prod_slot);
        send_request(OP_GET, 8'h00);
        send_request(OP_GET, 8'h00);
        send_request(OP_NEW, 8'h00);      // drop again
        send_request(OP_PUTBACK, sb.cons_slot);
        send_request(OP_ABORT, sb.prod_slot);
        send_request(OP_GET, 8'h00);
        send_request(OP_RELEASE, sb.cons_slot);
        send_request(OP_NEW, 8'h00);
        write_pool_size(9'd511);
        send_request(OP_NEW, 8'hff);
        send_request(OP_ABORT, 8'hff);

        sizes = '{9'd2, 9'd3, 9'd8, 9'd256, 9'd1, 9'd200};
        foreach (sizes[k]) begin
            write_pool_size(sizes[k]);
            calm = (k == 2);
            if (k == 1) hold_off_req = 1;
            for (int n = 0; n < 310; n++) random_request();
            calm = 0;
        end
        drain_results();
        if (sb.err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
